// File: rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared constants, register codes and clamp helper for the pid controller
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_GAIN_FRAC_BITS = 8;
    localparam int GAIN_BITS          = 16;
    localparam int CFG_IDX_W          = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_INTEG  = 3'd1,
        REG_GAIN_DERIV  = 3'd2,
        REG_OUT_HIGH    = 3'd3,
        REG_OUT_LOW     = 3'd4,
        REG_INIT_PROC   = 3'd5
    } pidc_reg_t;

    // upper limit tested first: with inverted limits, values above it resolve to it, all others to the lower one
    function automatic logic signed [63:0] clamp_s64(
        input logic signed [63:0] v,
        input logic signed [63:0] hi,
        input logic signed [63:0] lo
    );
        logic signed [63:0] r;
        priority if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: rtl/pidc_stream_if.sv
// ----------------------------------------------------------------------------
// pidc stream interfaces
// valid/ready channels for sample requests and drive results
// ----------------------------------------------------------------------------
interface pidc_in_if #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// File: rtl/pidc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// gain, limit and initial process registers with write decode
// ----------------------------------------------------------------------------
module pidc_cfg_regs #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH,
    parameter int CFG_W        = pidc_pkg::GAIN_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]                      cfg_data,
    output logic signed [pidc_pkg::GAIN_BITS-1:0] gain_prop,
    output logic signed [pidc_pkg::GAIN_BITS-1:0] gain_integ,
    output logic signed [pidc_pkg::GAIN_BITS-1:0] gain_deriv,
    output logic signed [SAMPLE_WIDTH-1:0]        out_high,
    output logic signed [SAMPLE_WIDTH-1:0]        out_low,
    output logic                                  reinit,
    output logic signed [SAMPLE_WIDTH-1:0]        reinit_value
);
    import pidc_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] HIGH_RST =
        SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 2);

    logic signed [GAIN_BITS-1:0]    gain_prop_reg;
    logic signed [GAIN_BITS-1:0]    gain_integ_reg;
    logic signed [GAIN_BITS-1:0]    gain_deriv_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_high_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_low_reg;
    logic                           reinit_next;

    always_comb
    begin
        reinit_next = 1'b0;
        if (cfg_we && (pidc_reg_t'(cfg_index) == REG_INIT_PROC))
        begin
            reinit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            out_high_reg   <= HIGH_RST;
            out_low_reg    <= -HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (pidc_reg_t'(cfg_index))
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_INTEG: gain_integ_reg <= cfg_data[GAIN_BITS-1:0];
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_data[GAIN_BITS-1:0];
                REG_OUT_HIGH:   out_high_reg   <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_OUT_LOW:    out_low_reg    <= cfg_data[SAMPLE_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    assign gain_prop    = gain_prop_reg;
    assign gain_integ   = gain_integ_reg;
    assign gain_deriv   = gain_deriv_reg;
    assign out_high     = out_high_reg;
    assign out_low      = out_low_reg;
    assign reinit       = reinit_next;
    assign reinit_value = cfg_data[SAMPLE_WIDTH-1:0];

endmodule

// File: rtl/pidc_state_stage.sv
// ----------------------------------------------------------------------------
// pidc_state_stage
// error, clamped integrator and process change; holds the loop state
// ----------------------------------------------------------------------------
module pidc_state_stage #(
    parameter int SAMPLE_WIDTH = pidc_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [SAMPLE_WIDTH-1:0] target,
    input  logic signed [SAMPLE_WIDTH-1:0] measured,
    input  logic signed [SAMPLE_WIDTH-1:0] out_high,
    input  logic signed [SAMPLE_WIDTH-1:0] out_low,
    input  logic                           reinit,
    input  logic signed [SAMPLE_WIDTH-1:0] reinit_value,
    output logic signed [SAMPLE_WIDTH:0]   err,
    output logic signed [SAMPLE_WIDTH-1:0] integ,
    output logic signed [SAMPLE_WIDTH:0]   delta
);
    import pidc_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] integ_sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] integ_sum_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_meas_reg;
    logic signed [SAMPLE_WIDTH:0]   err_next;
    logic signed [SAMPLE_WIDTH:0]   delta_next;
    logic signed [SAMPLE_WIDTH+1:0] integ_raw;
    logic signed [SAMPLE_WIDTH:0]   err_reg;
    logic signed [SAMPLE_WIDTH-1:0] integ_reg;
    logic signed [SAMPLE_WIDTH:0]   delta_reg;

    always_comb
    begin
        err_next       = (SAMPLE_WIDTH+1)'(target) - (SAMPLE_WIDTH+1)'(measured);
        delta_next     = (SAMPLE_WIDTH+1)'(measured) - (SAMPLE_WIDTH+1)'(prev_meas_reg);
        integ_raw      = (SAMPLE_WIDTH+2)'(integ_sum_reg) + (SAMPLE_WIDTH+2)'(err_next);
        integ_sum_next = SAMPLE_WIDTH'(clamp_s64(64'(integ_raw), 64'(out_high),
                                                 64'(out_low)));
    end

    // loop state: reset to zero; a reinit write clears the integrator and loads the written process value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_sum_reg <= '0;
            prev_meas_reg <= '0;
        end
        else if (reinit)
        begin
            integ_sum_reg <= '0;
            prev_meas_reg <= reinit_value;
        end
        else if (accept)
        begin
            integ_sum_reg <= integ_sum_next;
            prev_meas_reg <= measured;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_sum_next;
            delta_reg <= delta_next;
        end
    end

    assign err   = err_reg;
    assign integ = integ_reg;
    assign delta = delta_reg;

endmodule

// File: rtl/pidc_mac_pipe.sv
// ----------------------------------------------------------------------------
// pidc_mac_pipe
// gain products, sum, scale and output clamp with valid/ready stage control
// ----------------------------------------------------------------------------
module pidc_mac_pipe #(
    parameter int SAMPLE_WIDTH   = pidc_pkg::DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRAC_BITS = pidc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_WIDTH:0]          err,
    input  logic signed [SAMPLE_WIDTH-1:0]        integ,
    input  logic signed [SAMPLE_WIDTH:0]          delta,
    input  logic signed [pidc_pkg::GAIN_BITS-1:0] gain_prop,
    input  logic signed [pidc_pkg::GAIN_BITS-1:0] gain_integ,
    input  logic signed [pidc_pkg::GAIN_BITS-1:0] gain_deriv,
    input  logic signed [SAMPLE_WIDTH-1:0]        out_high,
    input  logic signed [SAMPLE_WIDTH-1:0]        out_low,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        drive
);
    import pidc_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + GAIN_BITS + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic                           s1_valid_reg;
    logic                           s2_valid_reg;
    logic                           s1_ready;
    logic                           s2_ready;
    logic                           s2_load;
    logic signed [PROD_W-1:0]       prod_p;
    logic signed [PROD_W-1:0]       prod_i;
    logic signed [PROD_W-1:0]       prod_d;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        scaled;
    logic signed [SAMPLE_WIDTH-1:0] drive_next;
    logic signed [SAMPLE_WIDTH-1:0] drive_reg;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_load  = s1_valid_reg && s2_ready;

    always_comb
    begin
        prod_p     = PROD_W'(err) * PROD_W'(gain_prop);
        prod_i     = PROD_W'(integ) * PROD_W'(gain_integ);
        prod_d     = PROD_W'(delta) * PROD_W'(gain_deriv);
        sum        = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
        scaled     = sum >>> GAIN_FRAC_BITS;
        drive_next = SAMPLE_WIDTH'(clamp_s64(64'(scaled), 64'(out_high), 64'(out_low)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= accept;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign drive     = drive_reg;

endmodule

// File: rtl/pid_controller_clamped_top.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// fixed-point pid controller, derivative on measurement, clamped integrator
// ----------------------------------------------------------------------------
//  channel   | dir | payload                       | handshake
//  ----------+-----+-------------------------------+--------------------------
//  in_ch     | in  | target, measured (signed)     | valid/ready
//  out_ch    | out | drive (signed, clamped)       | valid/ready
//  cfg port  | in  | cfg_index, cfg_data           | cfg_we, no wait
//
//  one request accepted per cycle while in_ch.ready is high; drive passes the
//  input register of error, integrator and process change, then the
//  product/sum/clamp result register
//  the integrator and previous sample update at acceptance, so the loop state
//  recurrence closes within the state stage
//  reset clears the integrator, loads zero into the previous sample and sets
//  the limits to +1.0/-1.0
//  a stalled output holds both stages; in_ch.ready drops only once both
//  stages are full and out_ch.ready is low
// ----------------------------------------------------------------------------
module pid_controller_clamped_top #(
    parameter int SAMPLE_WIDTH   = pidc_pkg::DEF_SAMPLE_WIDTH,
    parameter int GAIN_FRAC_BITS = pidc_pkg::DEF_GAIN_FRAC_BITS,
    parameter int CFG_W          = (SAMPLE_WIDTH > pidc_pkg::GAIN_BITS) ?
                                   SAMPLE_WIDTH : pidc_pkg::GAIN_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pidc_in_if.sink                        in_ch,
    pidc_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_data
);
    import pidc_pkg::*;

    // configuration values
    logic signed [GAIN_BITS-1:0]    gain_prop;
    logic signed [GAIN_BITS-1:0]    gain_integ;
    logic signed [GAIN_BITS-1:0]    gain_deriv;
    logic signed [SAMPLE_WIDTH-1:0] out_high;
    logic signed [SAMPLE_WIDTH-1:0] out_low;
    logic                           reinit;
    logic signed [SAMPLE_WIDTH-1:0] reinit_value;

    // first stage results
    logic signed [SAMPLE_WIDTH:0]   err;
    logic signed [SAMPLE_WIDTH-1:0] integ;
    logic signed [SAMPLE_WIDTH:0]   delta;

    logic                           in_ready;
    logic                           accept;

    assign accept      = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    pidc_cfg_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CFG_W        (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .gain_prop    (gain_prop),
        .gain_integ   (gain_integ),
        .gain_deriv   (gain_deriv),
        .out_high     (out_high),
        .out_low      (out_low),
        .reinit       (reinit),
        .reinit_value (reinit_value)
    );

    // error, integrator clamp and process change; owns the loop state
    pidc_state_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .target       (in_ch.target),
        .measured     (in_ch.measured),
        .out_high     (out_high),
        .out_low      (out_low),
        .reinit       (reinit),
        .reinit_value (reinit_value),
        .err          (err),
        .integ        (integ),
        .delta        (delta)
    );

    // three gain products, then sum, scale by the gain fraction and clamp
    pidc_mac_pipe #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_ready   (in_ready),
        .err        (err),
        .integ      (integ),
        .delta      (delta),
        .gain_prop  (gain_prop),
        .gain_integ (gain_integ),
        .gain_deriv (gain_deriv),
        .out_high   (out_high),
        .out_low    (out_low),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .drive      (out_ch.drive)
    );

endmodule

// File: rtl/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker
// port-level checks on request flow and back-pressure of the pid controller
// ----------------------------------------------------------------------------
module pidc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // a result never shows without an accepted request behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != 3'd0))
        else $error("result shown with no request in flight");

    // never more requests in flight than pipeline stages
    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd2)
        else $error("more requests in flight than stages");

    // input stalls only under output back-pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before it was taken");

endmodule

bind pid_controller_clamped_top pidc_checker u_pidc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);

// File: tb/tb_pid_controller_clamped_top.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped_top
// self-checking bench for the clamped pid controller: a cycle-free loop model
// predicts every drive value, directed tests cover reset values, full-scale
// gains and samples, inverted limits, process reload and spare register
// indexes, then randomized tuning phases run with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int SW         = DEF_SAMPLE_WIDTH;
    localparam int FRAC       = DEF_GAIN_FRAC_BITS;
    localparam int CFG_W      = (SW > GAIN_BITS) ? SW : GAIN_BITS;
    localparam int IDLE_LIMIT = 2000;   // cycles with no request and no drive
    localparam int SETTLE     = 8;      // pipeline is 2 deep, keep some margin
    localparam int HOLD_LONG  = 200;    // long output stall, fills all stages

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] ONE   = SW'(1) <<< (SW-2);   // +1.0 in q1.14
    localparam logic signed [SW-1:0] UNITY = SW'(1) <<< FRAC;     // gain of 1.0

    // register indexes past the last defined one, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pidc_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    pidc_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    pid_controller_clamped_top #(
        .SAMPLE_WIDTH   (SW),
        .GAIN_FRAC_BITS (FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // loop model: tuning registers and the two state words
    // ------------------------------------------------------------------
    logic signed [SW-1:0] k_prop, k_integ, k_deriv;
    logic signed [SW-1:0] lim_high, lim_low, proc_init;
    logic signed [SW-1:0] integ_acc, last_meas;

    logic signed [SW-1:0] drive_queue[$];   // predicted drive values, oldest first

    int err_count   = 0;
    int idle_cycles = 0;
    bit src_gaps    = 1'b0;   // sender inserts random gaps
    bit sink_stalls = 1'b0;   // receiver drops ready at random
    int hold_cycles = 0;      // long receiver hold-off, counted by the sink

    // upper limit tested first: with inverted limits only values above it resolve to it
    function automatic longint clip_to_limits(input longint v);
        if (v > longint'(lim_high))
            return longint'(lim_high);
        if (v < longint'(lim_low))
            return longint'(lim_low);
        return v;
    endfunction

    // one controller step: updates integrator and last sample, returns drive
    function automatic logic signed [SW-1:0] advance_loop(
        input logic signed [SW-1:0] tgt,
        input logic signed [SW-1:0] meas
    );
        longint err, delta, acc, res;
        err       = longint'(tgt) - longint'(meas);
        res       = clip_to_limits(longint'(integ_acc) + err);
        integ_acc = res[SW-1:0];
        delta     = longint'(meas) - longint'(last_meas);
        acc       = longint'(k_prop) * err + longint'(k_integ) * longint'(integ_acc)
                  + longint'(k_deriv) * delta;
        last_meas = meas;
        // arithmetic shift on a signed 64-bit value floors toward minus infinity
        res       = clip_to_limits(acc >>> FRAC);
        return res[SW-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SW-1:0] pick_edge();
        case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SW-1:0] exp_val,
                                   input logic signed [SW-1:0] got_val);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, exp_val, got_val);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // register write, model follows the same write
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_GAIN_PROP:  k_prop   = data;
            REG_GAIN_INTEG: k_integ  = data;
            REG_GAIN_DERIV: k_deriv  = data;
            REG_OUT_HIGH:   lim_high = data;
            REG_OUT_LOW:    lim_low  = data;
            REG_INIT_PROC:
            begin
                // reload restarts the loop: last sample and integrator
                proc_init = data;
                last_meas = data;
                integ_acc = '0;
            end
            default: ;  // spare index, nothing changes
        endcase
    endtask

    // ------------------------------------------------------------------
    // sender: offers one request, holds it until accepted, then predicts
    // valid stays high between back-to-back requests
    // ------------------------------------------------------------------
    task automatic send_request(input logic signed [SW-1:0] tgt,
                                input logic signed [SW-1:0] meas);
        int gap;
        gap = (src_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.target   = tgt;
        in_ch.measured = meas;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        drive_queue.push_back(advance_loop(tgt, meas));
    endtask

    // stop offering and let every predicted drive come out
    task automatic wait_drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
    endtask

    // drained plus the SETTLE margin, safe point for register writes
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random ready, plus the long hold-off when asked for
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // drive checker, compares every accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_drive
        logic signed [SW-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (drive_queue.size() == 0)
                report_mismatch("drive with no request pending", '0, out_ch.drive);
            else
            begin
                want = drive_queue.pop_front();
                if (out_ch.drive !== want)
                    report_mismatch("drive", want, out_ch.drive);
            end
        end
    end

    // watchdog: too long without any request or drive moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d drives pending",
                         idle_cycles, drive_queue.size());
                $display("tb_pid_controller_clamped_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset tuning: zero gains give zero drive, then default limits and the
    // zero previous sample show up once gains are set
    task automatic test_reset_state();
        send_request('0, '0);
        send_request(ONE, -ONE);
        send_request(S_MIN, S_MAX);
        wait_idle();
        cfg_write(REG_INIT_PROC, '0);       // back to a clean loop
        cfg_write(REG_GAIN_PROP, UNITY);
        cfg_write(REG_GAIN_DERIV, -(UNITY >>> 1));
        send_request(S_MAX, S_MIN);         // clamps at +1.0
        send_request(S_MIN, S_MAX);         // clamps at -1.0
        send_request(16'sd100, 16'sd50);
    endtask

    // full-scale limits, gains and samples of both signs
    task automatic test_full_scale();
        wait_idle();
        cfg_write(REG_OUT_HIGH, S_MAX);
        cfg_write(REG_OUT_LOW, S_MIN);
        cfg_write(REG_GAIN_PROP, S_MAX);
        cfg_write(REG_GAIN_INTEG, S_MIN);
        cfg_write(REG_GAIN_DERIV, S_MAX);
        send_request(S_MAX, S_MIN);
        send_request(S_MIN, S_MAX);
        send_request(S_MAX, S_MAX);
        send_request('1, '0);
        wait_idle();
        cfg_write(REG_GAIN_PROP, S_MIN);
        cfg_write(REG_GAIN_INTEG, S_MAX);
        cfg_write(REG_GAIN_DERIV, S_MIN);
        send_request('0, S_MIN);
        send_request(S_MAX, S_MIN);
    endtask

    // low limit above high limit: anything above high becomes high, only
    // values at or below high can fall to low
    task automatic test_inverted_limits();
        wait_idle();
        cfg_write(REG_GAIN_PROP, UNITY);
        cfg_write(REG_GAIN_INTEG, UNITY);
        cfg_write(REG_GAIN_DERIV, '0);
        cfg_write(REG_OUT_HIGH, -16'sd4096);
        cfg_write(REG_OUT_LOW, 16'sd4096);
        send_request(16'sd1000, '0);
        send_request(-16'sd1000, '0);
        send_request('0, '0);
    endtask

    // writing the initial process value reloads the last sample and clears
    // the integrator in the middle of a run
    task automatic test_process_reload();
        wait_idle();
        cfg_write(REG_OUT_HIGH, S_MAX);
        cfg_write(REG_OUT_LOW, S_MIN);
        cfg_write(REG_INIT_PROC, 16'sd12000);
        send_request('0, 16'sd12000);
        send_request('0, -16'sd12000);
        wait_idle();
        cfg_write(REG_INIT_PROC, S_MIN);
        send_request('0, S_MAX);
    endtask

    // writes to indexes past the register list must change nothing
    task automatic test_spare_index();
        wait_idle();
        cfg_write(REG_SPARE_LO, S_MAX);
        cfg_write(REG_SPARE_HI, S_MIN);
        send_request(16'sd2000, 16'sd500);
        send_request(-16'sd2000, 16'sd500);
    endtask

    // receiver holds off long enough for all stages to fill, sender keeps
    // offering back to back and must see ready drop
    task automatic test_output_hold();
        wait_idle();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        hold_cycles = HOLD_LONG;
        repeat (30)
            send_request(SW'($urandom), SW'($urandom));
    endtask

    // sender stops until every drive is out, then picks up again
    task automatic test_sender_pause();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        repeat (10)
            send_request(SW'($urandom), SW'($urandom));
        wait_drain();
        repeat (10)
            send_request(SW'($urandom), SW'($urandom));
    endtask

    // gains drawn within +-span, or over the whole range when span is zero
    task automatic set_random_gains(input int span);
        wait_idle();
        if (span == 0)
        begin
            cfg_write(REG_GAIN_PROP, CFG_W'($urandom));
            cfg_write(REG_GAIN_INTEG, CFG_W'($urandom));
            cfg_write(REG_GAIN_DERIV, CFG_W'($urandom));
        end
        else
        begin
            cfg_write(REG_GAIN_PROP, CFG_W'(int'($urandom_range(0, 2 * span)) - span));
            cfg_write(REG_GAIN_INTEG, CFG_W'(int'($urandom_range(0, 2 * span)) - span));
            cfg_write(REG_GAIN_DERIV, CFG_W'(int'($urandom_range(0, 2 * span)) - span));
        end
    endtask

    // random limit pair, ordered or deliberately inverted
    task automatic set_random_limits(input bit inverted);
        logic signed [SW-1:0] a, b;
        a = SW'($urandom);
        b = SW'($urandom);
        if ((a > b) == inverted)
        begin
            cfg_write(REG_OUT_HIGH, b);
            cfg_write(REG_OUT_LOW, a);
        end
        else
        begin
            cfg_write(REG_OUT_HIGH, a);
            cfg_write(REG_OUT_LOW, b);
        end
    endtask

    // closed-loop style traffic: the process mostly creeps toward the
    // setpoint with noise, with setpoint steps, jumps and full-scale values
    task automatic run_loop_traffic(input int count);
        logic signed [SW-1:0] tgt, meas;
        longint               walk;
        int                   roll;
        tgt  = SW'($urandom);
        meas = SW'($urandom);
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                tgt = SW'($urandom);
            else if (roll < 20)
                tgt = pick_edge();
            roll = $urandom_range(0, 99);
            if (roll < 10)
                meas = pick_edge();
            else if (roll < 35)
                meas = SW'($urandom);
            else
            begin
                walk = longint'(meas) + (longint'(tgt) - longint'(meas)) / 8
                     + longint'(int'($urandom_range(0, 64))) - 32;
                if (walk > longint'(S_MAX))
                    walk = longint'(S_MAX);
                if (walk < longint'(S_MIN))
                    walk = longint'(S_MIN);
                meas = walk[SW-1:0];
            end
            send_request(tgt, meas);
        end
    endtask

    // several tuning settings in turn, with and without random idling
    task automatic test_random_tuning();
        // modest gains, nominal limits, idling on both sides
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        set_random_gains(1024);
        cfg_write(REG_OUT_HIGH, ONE);
        cfg_write(REG_OUT_LOW, -ONE);
        run_loop_traffic(150);

        // full-range gains and limits, no idling at all
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        set_random_gains(0);
        cfg_write(REG_OUT_HIGH, S_MAX);
        cfg_write(REG_OUT_LOW, S_MIN);
        run_loop_traffic(150);

        // random ordered limits and a fresh process value
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        set_random_gains(2048);
        set_random_limits(1'b0);
        cfg_write(REG_INIT_PROC, CFG_W'($urandom));
        run_loop_traffic(150);

        // full-range gains against inverted limits
        set_random_gains(0);
        set_random_limits(1'b1);
        run_loop_traffic(100);

        // gentle gains, random everything else
        set_random_gains(512);
        set_random_limits(1'b0);
        cfg_write(REG_INIT_PROC, CFG_W'($urandom));
        run_loop_traffic(150);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.target   = '0;
        in_ch.measured = '0;

        // model matches the block's reset tuning
        k_prop    = '0;
        k_integ   = '0;
        k_deriv   = '0;
        lim_high  = ONE;
        lim_low   = -ONE;
        proc_init = '0;
        integ_acc = '0;
        last_meas = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_full_scale();
        test_inverted_limits();
        test_process_reload();
        test_spare_index();
        test_output_hold();
        test_sender_pause();
        test_random_tuning();

        // everything predicted has to come out, watchdog bounds the wait
        wait_drain();
        repeat (SETTLE) @(posedge clk);

        if (err_count == 0)
            $display("tb_pid_controller_clamped_top: PASS");
        else
            $display("tb_pid_controller_clamped_top: FAIL");
        $finish;
    end

endmodule
